[sv/p25_dibit_block_interleaver_unit_defines.svh]
// Assertion macros used by the checker file of this block.
`ifndef P25_DIBIT_BLOCK_INTERLEAVER_UNIT_DEFINES_SVH
`define P25_DIBIT_BLOCK_INTERLEAVER_UNIT_DEFINES_SVH

// Implication that is switched off while reset is high.
`define P25_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication that also holds during reset.
`define P25_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/p25bi_pkg.sv]
package p25bi_pkg;

  localparam int GROUP_COUNT   = 49;
  localparam int SOFT_WIDTH_DF = 8;
  localparam int FIRST_DEPTH   = 13;
  localparam int OTHER_DEPTH   = 12;
  localparam int IDX_W         = $clog2(GROUP_COUNT);
  localparam int STORE_DEPTH   = 2 * GROUP_COUNT;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_COUNT - 1);

  // Configuration register indexes.
  localparam logic REG_DIRECTION = 1'b0;

  // Direction codes.
  localparam logic DIR_INTERLEAVE   = 1'b0;
  localparam logic DIR_DEINTERLEAVE = 1'b1;

  // Launch of one block read-out.
  typedef struct packed {
    logic go;
    logic bank;
    logic dir;
  } emit_start_t;

  // Read request toward the group store.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } rd_req_t;

  // First group index of column c in column-major order.
  function automatic logic [IDX_W-1:0] col_offset(input logic [1:0] c);
    logic [IDX_W-1:0] r;
    case (c)
      2'd0:    r = '0;
      2'd1:    r = IDX_W'(FIRST_DEPTH);
      2'd2:    r = IDX_W'(FIRST_DEPTH + OTHER_DEPTH);
      default: r = IDX_W'(FIRST_DEPTH + 2 * OTHER_DEPTH);
    endcase
    return r;
  endfunction

  // Last row index of column c.
  function automatic logic [3:0] col_last_row(input logic [1:0] c);
    return (c == 2'd0) ? 4'(FIRST_DEPTH - 1) : 4'(OTHER_DEPTH - 1);
  endfunction

  // Bank 0 holds entries 0..48, bank 1 entries 49..97.
  function automatic logic [STORE_AW-1:0] store_addr(input logic bank,
                                                     input logic [IDX_W-1:0] idx);
    return bank ? (STORE_AW'(idx) + STORE_AW'(GROUP_COUNT)) : STORE_AW'(idx);
  endfunction

endpackage

[sv/p25bi_store.sv]
module p25bi_store import p25bi_pkg::*; #(
  parameter int SOFT_WIDTH = SOFT_WIDTH_DF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [STORE_AW-1:0]           wr_addr,
  input  logic [4+4*SOFT_WIDTH-1:0]     wr_data,
  input  rd_req_t                       rd_req,
  output logic [4+4*SOFT_WIDTH-1:0]     rd_data
);

  localparam int GROUP_W = 4 + 4 * SOFT_WIDTH;

  logic [GROUP_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

[sv/p25bi_emit.sv]
module p25bi_emit import p25bi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  emit_start_t start_cmd,
  output rd_req_t     rd_req,
  output logic        out_valid,
  output logic        out_last
);

  logic             active, active_next;
  logic [IDX_W-1:0] k, k_next;
  logic [1:0]       c, c_next;
  logic [3:0]       m, m_next;
  logic             bank, bank_next;
  logic             dir, dir_next;
  logic [IDX_W-1:0] src;

  always_comb begin
    active_next = active;
    k_next      = k;
    c_next      = c;
    m_next      = m;
    bank_next   = bank;
    dir_next    = dir;
    // A new block can start on the very edge the previous read-out ends.
    if (start_cmd.go) begin
      active_next = 1'b1;
      k_next      = '0;
      c_next      = '0;
      m_next      = '0;
      bank_next   = start_cmd.bank;
      dir_next    = start_cmd.dir;
    end else if (active) begin
      k_next = k + 1'b1;
      if (k == LAST_IDX) begin
        active_next = 1'b0;
      end
      if (dir == DIR_DEINTERLEAVE) begin
        // Output walks rows: column is the fast index.
        c_next = c + 1'b1;
        if (c == 2'd3) begin
          m_next = m + 1'b1;
        end
      end else begin
        // Output walks columns: row is the fast index.
        if (m == col_last_row(c)) begin
          m_next = '0;
          c_next = c + 1'b1;
        end else begin
          m_next = m + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dir == DIR_DEINTERLEAVE) begin
      src = col_offset(c) + IDX_W'(m);
    end else begin
      src = {m, c};
    end
    rd_req.en   = active;
    rd_req.addr = store_addr(bank, src);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      active    <= active_next;
      out_valid <= active;
      out_last  <= active && (k == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    k    <= k_next;
    c    <= c_next;
    m    <= m_next;
    bank <= bank_next;
    dir  <= dir_next;
  end

endmodule

[sv/p25_dibit_block_interleaver_unit.sv]
// P25 dibit block interleaver for 196-bit blocks carried as 49 groups.
// Input: a group (hard_nibble and four soft values) is taken at each clock
// edge where start is high and busy is low. Groups are written in arrival
// order into one half of a two-bank store; the other half is read out.
// Output: when the 49th group of a block is taken, the block is read out
// permuted, one group per cycle, each shown for one cycle with strobe
// high; block_last marks the 49th. Taking the 49th group sets the read-out
// sequencer active; it issues the store read, and the read data and strobe
// are both registered from it.
// Throughput is one group per cycle: loading one bank overlaps reading the
// other, and the read-out sequencer can relaunch on the edge it finishes,
// so busy stays low. The store has one write and one registered read port.
// The direction register (APB, address 0, bit 0) picks interleave (0) or
// deinterleave (1); the value held when the 49th group arrives applies.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Reset clears the group counter, the bank select, the direction and any
// read-out in flight; store contents are left as they are.
module p25_dibit_block_interleaver_unit import p25bi_pkg::*; #(
  parameter int SOFT_WIDTH = SOFT_WIDTH_DF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   hard_nibble,
  input  logic signed [SOFT_WIDTH-1:0] soft_zero,
  input  logic signed [SOFT_WIDTH-1:0] soft_one,
  input  logic signed [SOFT_WIDTH-1:0] soft_two,
  input  logic signed [SOFT_WIDTH-1:0] soft_three,
  output logic                         strobe,
  output logic [3:0]                   out_hard_nibble,
  output logic signed [SOFT_WIDTH-1:0] out_soft_zero,
  output logic signed [SOFT_WIDTH-1:0] out_soft_one,
  output logic signed [SOFT_WIDTH-1:0] out_soft_two,
  output logic signed [SOFT_WIDTH-1:0] out_soft_three,
  output logic                         block_last
);

  localparam int GROUP_W = 4 + 4 * SOFT_WIDTH;

  logic               direction;
  logic [IDX_W-1:0]   load_count;
  logic               load_bank;
  logic               accept;
  logic               cfg_wr;
  emit_start_t        start_cmd;
  rd_req_t            rd_req;
  logic [GROUP_W-1:0] wr_data;
  logic [GROUP_W-1:0] rd_data;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DIRECTION) begin
      prdata = {31'b0, direction};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_INTERLEAVE;
    end else if (cfg_wr && (paddr[2] == REG_DIRECTION)) begin
      direction <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      load_bank  <= 1'b0;
    end else if (accept) begin
      if (load_count == LAST_IDX) begin
        load_count <= '0;
        load_bank  <= ~load_bank;
      end else begin
        load_count <= load_count + 1'b1;
      end
    end
  end

  assign wr_data = {hard_nibble, soft_three, soft_two, soft_one, soft_zero};

  always_comb begin
    start_cmd.go   = accept && (load_count == LAST_IDX);
    start_cmd.bank = load_bank;
    start_cmd.dir  = direction;
  end

  p25bi_store #(
    .SOFT_WIDTH(SOFT_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (store_addr(load_bank, load_count)),
    .wr_data (wr_data),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  p25bi_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start_cmd (start_cmd),
    .rd_req    (rd_req),
    .out_valid (strobe),
    .out_last  (block_last)
  );

  assign out_soft_zero   = rd_data[SOFT_WIDTH-1:0];
  assign out_soft_one    = rd_data[2*SOFT_WIDTH-1:SOFT_WIDTH];
  assign out_soft_two    = rd_data[3*SOFT_WIDTH-1:2*SOFT_WIDTH];
  assign out_soft_three  = rd_data[4*SOFT_WIDTH-1:3*SOFT_WIDTH];
  assign out_hard_nibble = rd_data[GROUP_W-1:4*SOFT_WIDTH];

endmodule

[sv/p25bi_checker.sv]
`include "p25_dibit_block_interleaver_unit_defines.svh"

module p25bi_checker import p25bi_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic block_last
);

  logic [IDX_W-1:0] in_cnt;
  logic [IDX_W-1:0] out_cnt;
  logic             in_acc;

  assign in_acc = start && !busy;

  // Position of the next input beat and the next output beat in a block.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
    end else begin
      if (in_acc) begin
        in_cnt <= (in_cnt == LAST_IDX) ? '0 : in_cnt + 1'b1;
      end
      if (strobe) begin
        out_cnt <= (out_cnt == LAST_IDX) ? '0 : out_cnt + 1'b1;
      end
    end
  end

  `P25_ASSERT_NEXT(a_reset_quiet, clk, rst, !strobe, "output beat right after reset")
  `P25_ASSERT_IMPL(a_last_has_strobe, clk, rst, block_last, strobe, "block_last without strobe")
  `P25_ASSERT_IMPL(a_readout_starts, clk, rst, in_acc && (in_cnt == LAST_IDX), ##2 strobe, "block read-out did not start")
  `P25_ASSERT_IMPL(a_last_position, clk, rst, strobe, (block_last == (out_cnt == LAST_IDX)), "block_last on wrong beat")

endmodule

bind p25_dibit_block_interleaver_unit p25bi_checker u_p25bi_checker (.*);
